>>> hw/rtl/delimited_telegram_checker_defines.svh
// delimited_telegram_checker_defines.svh: assertion macros for the telegram checker
// depends on: nothing; expects clk_i and rst_ni in the including module
`ifndef DELIMITED_TELEGRAM_CHECKER_DEFINES_SVH
`define DELIMITED_TELEGRAM_CHECKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define DTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/dtc_pkg.sv
// dtc_pkg: types and constants of the delimited telegram checker
// depends on: nothing
package dtc_pkg;

  // saturation limit of the per-frame byte counter
  localparam int unsigned COUNT_LIMIT = 255;
  localparam int unsigned CNT_W       = $clog2(COUNT_LIMIT + 1);

  localparam logic [7:0] DELIM_BYTE = 8'd177;
  localparam logic [7:0] SHORT_LEN  = 8'd11;
  localparam logic [7:0] LONG_LEN   = 8'd15;
  localparam logic [7:0] BYTES_MAX  = 8'd255;

  // byte positions inside a frame, counted from zero
  localparam logic [CNT_W-1:0] POS_LEN_HIGH   = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_LEN_LOW    = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_SHORT_CHK  = CNT_W'(8);
  localparam logic [CNT_W-1:0] POS_LONG_CHK   = CNT_W'(12);
  localparam logic [CNT_W-1:0] MIN_DELIM_CNT  = CNT_W'(3);
  localparam logic [CNT_W-1:0] SHORT_CNT      = CNT_W'(11);
  localparam logic [CNT_W-1:0] LONG_CNT       = CNT_W'(15);
  localparam logic [CNT_W-1:0] CNT_MAX        = CNT_W'(COUNT_LIMIT);

  typedef enum logic [1:0] {
    VERDICT_SHORT  = 2'd0,
    VERDICT_LONG   = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_e;

  typedef struct packed {
    logic       queue_empty;
    logic [7:0] data_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] frame_bytes;
    verdict_e   verdict;
  } result_t;

endpackage

>>> hw/rtl/dtc_in_reg.sv
// dtc_in_reg: input register stage of the telegram checker
// depends on: dtc_pkg
module dtc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dtc_pkg::rx_item_t item_i,
  output logic              valid_o,
  input  logic              take_i,
  output dtc_pkg::rx_item_t item_o
);
  import dtc_pkg::*;

  logic     valid_q, valid_d;
  rx_item_t item_q;

  // accept when empty or when the held transaction leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/dtc_frame.sv
// dtc_frame: per-frame state and verdict logic of the telegram checker
// depends on: dtc_pkg, delimited_telegram_checker_defines.svh
`include "delimited_telegram_checker_defines.svh"

module dtc_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  dtc_pkg::rx_item_t item_i,
  input  logic              res_ready_i,
  output logic              take_o,
  output logic              res_valid_o,
  output dtc_pkg::result_t  res_o
);
  import dtc_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]       prev_q, prev_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [7:0]       sum_q, sum_d;
  logic             short_ok_q, short_ok_d;
  logic             long_ok_q, long_ok_d;
  logic             delim, frame_end, sum_pos;
  logic [7:0]       b;
  verdict_e         verdict;

  assign take_o = valid_i && res_ready_i;
  assign b      = item_i.data_byte;

  // saturating count including this byte
  assign cnt_inc = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : CNT_MAX;

  assign sum_pos = (cnt_q == CNT_W'(3)) || (cnt_q == CNT_W'(5)) || (cnt_q == CNT_W'(7)) ||
                   (cnt_q == CNT_W'(9)) || (cnt_q == CNT_W'(11));

  assign delim = (cnt_inc >= MIN_DELIM_CNT) && (b == DELIM_BYTE) && (prev_q == DELIM_BYTE);
  assign frame_end = delim || item_i.queue_empty;

  // verdict; header and check flags are settled before the closing delimiter
  always_comb begin
    verdict = VERDICT_REJECT;
    if (delim && (len_hi_q == 8'd0)) begin
      if ((cnt_inc == SHORT_CNT) && (len_lo_q == SHORT_LEN) && short_ok_q) begin
        verdict = VERDICT_SHORT;
      end else if ((cnt_inc == LONG_CNT) && (len_lo_q == LONG_LEN) && long_ok_q) begin
        verdict = VERDICT_LONG;
      end
    end
  end

  // next frame state, cleared after a verdict
  always_comb begin
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    len_hi_d   = len_hi_q;
    len_lo_d   = len_lo_q;
    sum_d      = sum_q;
    short_ok_d = short_ok_q;
    long_ok_d  = long_ok_q;
    if (take_o) begin
      if (frame_end) begin
        cnt_d      = '0;
        prev_d     = '0;
        len_hi_d   = '0;
        len_lo_d   = '0;
        sum_d      = '0;
        short_ok_d = 1'b0;
        long_ok_d  = 1'b0;
      end else begin
        cnt_d  = cnt_inc;
        prev_d = b;
        if (cnt_q == POS_LEN_HIGH) begin
          len_hi_d = b;
        end
        if (cnt_q == POS_LEN_LOW) begin
          len_lo_d = b;
        end
        if (sum_pos) begin
          sum_d = sum_q + b;
        end
        if (cnt_q == POS_SHORT_CHK) begin
          short_ok_d = (b == sum_q);
        end
        if (cnt_q == POS_LONG_CHK) begin
          long_ok_d = (b == sum_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prev_q     <= '0;
      len_hi_q   <= '0;
      len_lo_q   <= '0;
      sum_q      <= '0;
      short_ok_q <= 1'b0;
      long_ok_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      prev_q     <= prev_d;
      len_hi_q   <= len_hi_d;
      len_lo_q   <= len_lo_d;
      sum_q      <= sum_d;
      short_ok_q <= short_ok_d;
      long_ok_q  <= long_ok_d;
    end
  end

  // result for the output register
  assign res_valid_o       = take_o && frame_end;
  assign res_o.verdict     = verdict;
  assign res_o.frame_bytes = (cnt_inc > CNT_W'(BYTES_MAX)) ? BYTES_MAX : 8'(cnt_inc);

  // a verdict restarts the frame
  `DTC_ASSERT_NEXT(a_clear_after_verdict, res_valid_o, cnt_q == '0 && sum_q == 8'd0)
  // a valid short frame carries exactly eleven bytes
  `DTC_ASSERT_SAME(a_short_len, res_valid_o && verdict == VERDICT_SHORT,
                   res_o.frame_bytes == SHORT_LEN)
  // a valid long frame carries exactly fifteen bytes
  `DTC_ASSERT_SAME(a_long_len, res_valid_o && verdict == VERDICT_LONG,
                   res_o.frame_bytes == LONG_LEN)
  // a frame without delimiter is always rejected
  `DTC_ASSERT_SAME(a_no_delim_reject, res_valid_o && !delim, verdict == VERDICT_REJECT)

endmodule

>>> hw/rtl/dtc_out_reg.sv
// dtc_out_reg: result register of the telegram checker
// depends on: dtc_pkg
module dtc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dtc_pkg::result_t res_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output dtc_pkg::result_t res_o
);
  import dtc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // load when empty or when the held result is taken this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hw/rtl/delimited_telegram_checker.sv
// Delimited telegram checker: checks received frames byte by byte, one verdict per frame.
// A frame-ending byte's transaction passes the input register, then the result register, before its verdict.
// Throughput: one byte per cycle while the result register can load; a held result stalls all bytes.
// Bytes that do not end a frame produce no result.
// Reset: rst_ni asynchronous active low, clears both stage valids and all frame state.
// depends on: dtc_pkg, dtc_in_reg, dtc_frame, dtc_out_reg
module delimited_telegram_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // queue_empty
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] verdict, [9:2] frame_bytes, [15:10] zero
);
  import dtc_pkg::*;

  rx_item_t in_item, reg_item;
  result_t  frame_res, out_res;
  logic     reg_valid, take, res_valid, out_ready;

  assign in_item.data_byte   = s_axis_tdata_i;
  assign in_item.queue_empty = s_axis_tlast_i;

  // input register
  dtc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .take_i  (take),
    .item_o  (reg_item)
  );

  // frame state and verdict
  dtc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (reg_valid),
    .item_i      (reg_item),
    .res_ready_i (out_ready),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (frame_res)
  );

  // result register
  dtc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .res_i   (frame_res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {6'd0, out_res.frame_bytes, 2'(out_res.verdict)};

endmodule

>>> dv/delimited_telegram_checker_tb.sv
// delimited_telegram_checker_tb: self-checking stream testbench for the telegram checker
// feeds directed and random frames, predicts one verdict per frame, compares on the output
// depends on: dtc_pkg, delimited_telegram_checker
module delimited_telegram_checker_tb;
  import dtc_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int {
    FLAW_NONE,
    FLAW_BIT,
    FLAW_LEN_HIGH,
    FLAW_LEN_SWAP,
    FLAW_CUT
  } flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;   // [7:0] data_byte
  logic        s_axis_tlast_i = 1'b0;   // queue_empty
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;          // [1:0] verdict, [9:2] frame_bytes, [15:10] zero

  // bytes waiting to be sent and verdicts waiting to be seen
  rx_item_t    rx_bytes_q[$];
  result_t     pending_verdicts[$];

  // frame state of the predictor
  int unsigned frame_pos;
  logic [7:0]  last_byte;
  logic [7:0]  len_high;
  logic [7:0]  len_low;
  logic [7:0]  odd_sum;
  bit          short_sum_ok;
  bit          long_sum_ok;

  int unsigned total_bytes;
  int unsigned bytes_sent;
  int unsigned n_short, n_long, n_reject, n_saturated;
  int unsigned mismatches;
  bit          quiet_tail;

  int unsigned in_gap, in_idle_pct;
  int unsigned out_gap, out_idle_pct;
  int unsigned n_verdicts_seen;

  delimited_telegram_checker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // clear the predicted frame state
  task automatic restart_frame();
    frame_pos    = 0;
    last_byte    = 8'd0;
    len_high     = 8'd0;
    len_low      = 8'd0;
    odd_sum      = 8'd0;
    short_sum_ok = 1'b0;
    long_sum_ok  = 1'b0;
  endtask

  // advance the frame state by one byte, queue a verdict when the frame ends
  task automatic track_rx_byte(input logic [7:0] b, input logic empty);
    int unsigned pos;
    int unsigned cnt;
    bit          delim;
    result_t     r;
    pos = frame_pos;
    if (pos == POS_LEN_HIGH) len_high = b;
    if (pos == POS_LEN_LOW) len_low = b;
    // odd positions from the length low byte through byte eleven
    if (pos >= POS_LEN_LOW && pos <= SHORT_CNT && pos[0]) odd_sum = odd_sum + b;
    if (pos == POS_SHORT_CHK) short_sum_ok = (b == odd_sum);
    if (pos == POS_LONG_CHK) long_sum_ok = (b == odd_sum);
    cnt   = (pos < COUNT_LIMIT) ? pos + 1 : COUNT_LIMIT;
    delim = (cnt >= MIN_DELIM_CNT) && (b == DELIM_BYTE) && (last_byte == DELIM_BYTE);
    if (!delim && !empty) begin
      frame_pos = cnt;
      last_byte = b;
      return;
    end
    r.verdict = VERDICT_REJECT;
    if (delim && len_high == 8'd0) begin
      if (cnt == SHORT_CNT && len_low == SHORT_LEN && short_sum_ok) begin
        r.verdict = VERDICT_SHORT;
      end else if (cnt == LONG_CNT && len_low == LONG_LEN && long_sum_ok) begin
        r.verdict = VERDICT_LONG;
      end
    end
    r.frame_bytes = (cnt > BYTES_MAX) ? BYTES_MAX : cnt[7:0];
    case (r.verdict)
      VERDICT_SHORT: n_short++;
      VERDICT_LONG:  n_long++;
      default:       n_reject++;
    endcase
    if (cnt >= COUNT_LIMIT) n_saturated++;
    pending_verdicts.push_back(r);
    restart_frame();
  endtask

  task automatic push_rx(input logic [7:0] b, input logic last);
    rx_item_t it;
    it.data_byte   = b;
    it.queue_empty = last;
    rx_bytes_q.push_back(it);
  endtask

  // payload byte that can never form a delimiter
  function automatic logic [7:0] body_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == DELIM_BYTE);
    return v;
  endfunction

  // well-formed short or long telegram, optionally damaged in one way
  task automatic queue_telegram(input bit is_long, input flaw_e flaw);
    logic [7:0] fr[15];
    logic [7:0] ck;
    int         n, cut, k;
    n = is_long ? LONG_CNT : SHORT_CNT;
    for (k = 0; k < n; k++) fr[k] = body_byte();
    fr[POS_LEN_HIGH] = 8'd0;
    fr[POS_LEN_LOW]  = is_long ? LONG_LEN : SHORT_LEN;
    ck = 8'd0;
    for (k = POS_LEN_LOW; k < n - 3; k += 2) ck = ck + fr[k];
    fr[n-3] = ck;
    fr[n-2] = DELIM_BYTE;
    fr[n-1] = DELIM_BYTE;
    cut = n;
    case (flaw)
      FLAW_BIT: begin
        k = $urandom_range(0, n - 3);
        fr[k] = fr[k] ^ (8'd1 << $urandom_range(0, 7));
      end
      FLAW_LEN_HIGH: fr[POS_LEN_HIGH] = 8'($urandom_range(1, 255));
      FLAW_LEN_SWAP: fr[POS_LEN_LOW] = is_long ? SHORT_LEN : LONG_LEN;
      FLAW_CUT:      cut = $urandom_range(1, n - 1);
      default: ;
    endcase
    for (k = 0; k < cut; k++) push_rx(fr[k], (flaw == FLAW_CUT) && (k == cut - 1));
  endtask

  // arbitrary bytes, rich in delimiter values, with stray empty flags
  task automatic queue_noise(input bit end_with_delim);
    int n, k;
    n = $urandom_range(1, 20);
    for (k = 0; k < n; k++) begin
      push_rx(($urandom_range(0, 3) == 0) ? DELIM_BYTE : 8'($urandom_range(0, 255)),
              (k == n - 1 && !end_with_delim) || ($urandom_range(0, 15) == 0));
    end
    if (end_with_delim) begin
      push_rx(DELIM_BYTE, 1'b0);
      push_rx(DELIM_BYTE, 1'($urandom_range(0, 1)));
    end
  endtask

  // long frame that can saturate the byte counter
  task automatic queue_overrun();
    int n, k;
    n = $urandom_range(250, 300);
    for (k = 0; k < n; k++) push_rx(body_byte(), 1'b0);
    if ($urandom_range(0, 1)) begin
      push_rx(DELIM_BYTE, 1'b0);
      push_rx(DELIM_BYTE, 1'b0);
    end else begin
      push_rx(body_byte(), 1'b1);
    end
  endtask

  // sender: presents queued bytes, predicts on every accepted transaction
  always @(posedge clk_i) begin : drive_rx
    rx_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'd0;
      s_axis_tlast_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        track_rx_byte(s_axis_tdata_i, s_axis_tlast_i);
        bytes_sent++;
        if (bytes_sent % 64 == 0) in_idle_pct = 10 * $urandom_range(0, 3);
        if (bytes_sent + QUIET_TAIL >= total_bytes) quiet_tail = 1'b1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (rx_bytes_q.size() > 0) begin
          nxt = rx_bytes_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.data_byte;
          s_axis_tlast_i  <= nxt.queue_empty;
          if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
            in_gap = $urandom_range(1, 11);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure, compare each verdict transaction
  always @(posedge clk_i) begin : watch_verdicts
    result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_o[9:0]);
        n_verdicts_seen++;
        if (n_verdicts_seen % 16 == 0) out_idle_pct = 10 * $urandom_range(0, 4);
        if (pending_verdicts.size() == 0) begin
          $error("unexpected verdict transaction: verdict %0d frame_bytes %0d",
                 got.verdict, got.frame_bytes);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            mismatches++;
          end
          if (got.frame_bytes !== want.frame_bytes) begin
            $error("frame_bytes: expected %0d, got %0d", want.frame_bytes, got.frame_bytes);
            mismatches++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 99) < out_idle_pct) begin
          out_gap = $urandom_range(1, 11);
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : run
    int    sel, frame_no, overruns;
    flaw_e flaw;
    restart_frame();
    in_idle_pct  = 20;
    out_idle_pct = 20;

    // directed: valid short and long telegrams, lone empty byte, shortest delimited frame
    queue_telegram(1'b0, FLAW_NONE);
    queue_telegram(1'b1, FLAW_NONE);
    push_rx(8'hFF, 1'b1);
    push_rx(8'h00, 1'b0);
    push_rx(DELIM_BYTE, 1'b0);
    push_rx(DELIM_BYTE, 1'b1);

    // random: mostly telegrams with random payload, some damaged, some noise
    frame_no = 0;
    overruns = 0;
    while (rx_bytes_q.size() < RANDOM_BYTES) begin
      frame_no++;
      sel  = $urandom_range(0, 99);
      flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE : flaw_e'($urandom_range(1, 4));
      if (frame_no % 37 == 0 && overruns < 2) begin
        queue_overrun();
        overruns++;
      end else if (sel < 40) begin
        queue_telegram(1'b0, flaw);
      end else if (sel < 70) begin
        queue_telegram(1'b1, flaw);
      end else if (sel < 85) begin
        queue_noise(1'b0);
      end else begin
        queue_noise(1'b1);
      end
    end
    total_bytes = rx_bytes_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes_q.size() != 0 || s_axis_tvalid_i || pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      mismatches++;
    end

    $display("Sent %0d bytes; frames: %0d valid short, %0d valid long, %0d rejected",
             bytes_sent, n_short, n_long, n_reject);
    $display("%0d frames hit the byte count limit", n_saturated);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
